// ----- hw/rtl/sst_pkg.sv -----
// shared constants, types and request codes for the sorted score table
`timescale 1ns / 1ps
package sst_pkg;

    localparam int DEPTH    = 16;
    localparam int TAG_BITS = 64;
    localparam int SCORE_W  = 32;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef logic [1:0] t_req;

    localparam t_req REQ_PUSH  = 2'd0;
    localparam t_req REQ_QUERY = 2'd1;
    localparam t_req REQ_DUMP  = 2'd2;

    typedef struct packed {
        logic [SCORE_W-1:0]  score;
        logic [TAG_BITS-1:0] tag;
    } t_rec;

    typedef struct packed {
        logic push;
        logic rotate;
        t_rec new_rec;
    } t_cell_ctl;

endpackage

// ----- hw/rtl/sst_cell.sv -----
// one slot of the sorted chain: insert-shift on push, rotate on dump
`timescale 1ns / 1ps
module sst_cell (
    input  logic               i_clk,
    input  sst_pkg::t_cell_ctl i_ctl,
    input  logic               i_occ,
    input  logic               i_tail,
    input  sst_pkg::t_rec      i_prev_rec,
    input  logic               i_prev_less,
    input  sst_pkg::t_rec      i_next_rec,
    input  sst_pkg::t_rec      i_wrap_rec,
    output sst_pkg::t_rec      o_rec,
    output logic               o_less
);

    sst_pkg::t_rec r_rec;

    assign o_less = i_occ && ($signed(r_rec.score) < $signed(i_ctl.new_rec.score));
    assign o_rec  = r_rec;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            if (i_prev_less) begin
                r_rec <= i_prev_rec;
            end else if (!i_occ || o_less) begin
                r_rec <= i_ctl.new_rec;
            end
        end else if (i_ctl.rotate) begin
            r_rec <= i_tail ? i_wrap_rec : i_next_rec;
        end
    end

endmodule

// ----- hw/rtl/sorted_score_table_top.sv -----
// top level: request control, record count and the chain of sorted cells
`timescale 1ns / 1ps
// Records are held in descending score order, equal scores in arrival order.
// Push, query and an unused request code each give one result on the cycle
// after the transaction; busy stays low. A dump of an empty table gives its
// one result the same way. A non-empty dump raises busy after the transaction
// while the chain rotates its occupied cells once past the head cell, and the
// records are registered from the head cell onto the outputs, one per cycle,
// so the next transaction can be accepted once busy falls again. Results are
// strobed on o_valid for one cycle only and must be captured then.
module sorted_score_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_score,
    input  logic [63:0] i_name_tag,
    output logic        o_valid,
    output logic        o_is_highest,
    output logic        o_push_rejected,
    output logic        o_entry_valid,
    output logic [31:0] o_entry_score,
    output logic [63:0] o_entry_tag,
    output logic        o_last
);

    typedef enum logic {ST_IDLE, ST_DUMP} t_state;

    localparam int DEPTH = sst_pkg::DEPTH;
    localparam int CNT_W = sst_pkg::CNT_W;
    localparam int IDX_W = sst_pkg::IDX_W;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_count;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_valid;
    logic                     r_is_highest;
    logic                     r_push_rejected;
    logic                     r_entry_valid;
    logic [31:0]              r_entry_score;
    logic [63:0]              r_entry_tag;
    logic                     r_last;

    logic                     accept;
    logic                     full;
    logic                     dump_last;
    sst_pkg::t_cell_ctl       ctl;
    sst_pkg::t_rec            rec   [DEPTH];
    logic                     less  [DEPTH];
    logic                     occ   [DEPTH];
    logic                     tail  [DEPTH];

    assign busy      = (r_state == ST_DUMP);
    assign accept    = start && !busy;
    assign full      = (r_count == CNT_W'(DEPTH));
    assign dump_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    assign ctl.push           = accept && (i_req_type == sst_pkg::REQ_PUSH) && !full;
    assign ctl.rotate         = busy;
    assign ctl.new_rec.score  = i_score;
    assign ctl.new_rec.tag    = i_name_tag[sst_pkg::TAG_BITS-1:0];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            sst_pkg::t_rec prev_rec;
            sst_pkg::t_rec next_rec;
            logic          prev_less;

            assign occ[g]  = (CNT_W'(g) < r_count);
            assign tail[g] = (r_count == CNT_W'(g + 1));

            if (g == 0) begin : g_head
                assign prev_rec  = ctl.new_rec;
                assign prev_less = 1'b0;
            end else begin : g_body
                assign prev_rec  = rec[g-1];
                assign prev_less = less[g-1];
            end

            if (g == DEPTH - 1) begin : g_end
                assign next_rec = rec[0];
            end else begin : g_mid
                assign next_rec = rec[g+1];
            end

            sst_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_occ       (occ[g]),
                .i_tail      (tail[g]),
                .i_prev_rec  (prev_rec),
                .i_prev_less (prev_less),
                .i_next_rec  (next_rec),
                .i_wrap_rec  (rec[0]),
                .o_rec       (rec[g]),
                .o_less      (less[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid         <= 1'b0;
            r_is_highest    <= 1'b0;
            r_push_rejected <= 1'b0;
            r_entry_valid   <= 1'b0;
            r_entry_score   <= '0;
            r_entry_tag     <= '0;
            r_last          <= 1'b1;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        priority if (i_req_type == sst_pkg::REQ_PUSH) begin
                            r_valid         <= 1'b1;
                            r_push_rejected <= full;
                            if (!full) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                        end else if (i_req_type == sst_pkg::REQ_QUERY) begin
                            r_valid      <= 1'b1;
                            r_is_highest <= !occ[0] ||
                                            !($signed(rec[0].score) > $signed(i_score));
                        end else if (i_req_type == sst_pkg::REQ_DUMP) begin
                            if (r_count == '0) begin
                                r_valid <= 1'b1;
                            end else begin
                                r_state <= ST_DUMP;
                                r_idx   <= '0;
                            end
                        end else begin
                            r_valid <= 1'b1;
                        end
                    end
                end
                ST_DUMP: begin
                    r_valid       <= 1'b1;
                    r_entry_valid <= 1'b1;
                    r_entry_score <= rec[0].score;
                    r_entry_tag   <= 64'(rec[0].tag);
                    r_last        <= dump_last;
                    r_idx         <= r_idx + IDX_W'(1);
                    if (dump_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_is_highest    = r_is_highest;
    assign o_push_rejected = r_push_rejected;
    assign o_entry_valid   = r_entry_valid;
    assign o_entry_score   = r_entry_score;
    assign o_entry_tag     = r_entry_tag;
    assign o_last          = r_last;

endmodule
